[rtl/sorted_soft_timer_queue_core_defines.svh]
// Assertion macros shared by the timer queue checker.
// No dependencies; include with the bare file name.
`ifndef SORTED_SOFT_TIMER_QUEUE_CORE_DEFINES_SVH
`define SORTED_SOFT_TIMER_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSTQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue assertion failed");

`endif

[rtl/sstq_pkg.sv]
// Shared types and constants of the sorted soft timer queue.
// No dependencies; used by the core and its checker.
package sstq_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int ID_W        = 4;
    localparam int IDX_W       = $clog2(NUM_TIMERS);
    localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
    localparam int TICK_W      = 64;
    localparam int DELAY_W     = 32;
    localparam int MAX_EXPIRE  = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_CREATE = 2'd1,
        ACT_START  = 2'd2,
        ACT_STOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_REPLY     = 2'd0,
        KIND_EXPIRED   = 2'd1,
        KIND_IDLE_TICK = 2'd2
    } t_kind;

endpackage

[rtl/sstq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sstq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/sorted_soft_timer_queue_core.sv]
// Sorted soft timer queue: 64-bit tick counter, 16 timer slots and an expiry-ordered list.
// Depends on sstq_pkg and sstq_ram (expiry store).
//
// Commands arrive on the slave stream; replies and expiries leave on the master stream.
// One comparator walks the ordered list through the single read port of the expiry RAM,
// with a read state and a compare state for each entry; the slot search of create and stop
// needs no RAM read and moves one entry per cycle. Create and stop search the list when the
// slot is running, start runs an insertion search, and a tick walks the head of the list
// until an unexpired entry or an empty list ends the walk, at most 16 expiries per tick.
// A stalled output adds its wait. The block takes no new command while one is in progress;
// a finished result waits in the output register. The expiry of a slot that was never
// created is undefined.
module sorted_soft_timer_queue_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] timer_id, [35:4] delay, [39:36] zero
    input  logic [sstq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] timer_id_res, [4] failed, [7:5] zero
    output logic [sstq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] kind
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int N     = sstq_pkg::NUM_TIMERS;
    localparam int IDX_W = sstq_pkg::IDX_W;
    localparam int CNT_W = sstq_pkg::CNT_W;
    localparam logic [CNT_W-1:0] MAX_K = CNT_W'(sstq_pkg::MAX_EXPIRE);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_ST_LD,
        S_W_RD,
        S_W_CMP,
        S_INSERT,
        S_T_RD,
        S_T_CMP,
        S_T_LAST,
        S_EMIT
    } t_state;

    t_state                      r_state, n_state;
    logic [sstq_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [N-1:0]                r_running, n_running;
    logic [IDX_W-1:0]            r_order [N];
    logic [IDX_W-1:0]            n_order [N];
    logic [CNT_W-1:0]            r_len, n_len;
    logic [CNT_W-1:0]            r_pos, n_pos;
    logic [CNT_W-1:0]            r_k, n_k;
    logic [sstq_pkg::ID_W-1:0]   r_id, n_id;
    logic                        r_fail, n_fail;
    logic [sstq_pkg::TICK_W-1:0] r_new_exp, n_new_exp;
    logic                        r_pend, n_pend;
    logic [IDX_W-1:0]            r_pend_id, n_pend_id;

    logic                        r_out_valid, n_out_valid;
    sstq_pkg::t_kind             r_out_kind, n_out_kind;
    logic [sstq_pkg::ID_W-1:0]   r_out_id, n_out_id;
    logic                        r_out_fail, n_out_fail;
    logic                        r_out_last, n_out_last;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [sstq_pkg::TICK_W-1:0] ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [sstq_pkg::TICK_W-1:0] ram_rdata;

    sstq_pkg::t_action            in_action;
    logic [sstq_pkg::ID_W-1:0]    in_id;
    logic [sstq_pkg::DELAY_W-1:0] in_delay;
    logic                         in_ok;
    logic                         accept;
    logic                         out_free;

    assign in_action = sstq_pkg::t_action'(s_axis_tuser);
    assign in_id     = s_axis_tdata[sstq_pkg::ID_W-1:0];
    assign in_delay  = s_axis_tdata[sstq_pkg::ID_W +: sstq_pkg::DELAY_W];
    assign in_ok     = (32'(in_id) < N);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    sstq_ram #(
        .WIDTH (sstq_pkg::TICK_W),
        .DEPTH (N)
    ) u_expiry (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_running   = r_running;
        n_order     = r_order;
        n_len       = r_len;
        n_pos       = r_pos;
        n_k         = r_k;
        n_id        = r_id;
        n_fail      = r_fail;
        n_new_exp   = r_new_exp;
        n_pend      = r_pend;
        n_pend_id   = r_pend_id;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_fail  = r_out_fail;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = in_id[IDX_W-1:0];
        ram_wdata   = r_tick + sstq_pkg::TICK_W'(in_delay);
        ram_raddr   = in_id[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id   = in_id;
                    n_pos  = '0;
                    n_fail = 1'b0;
                    unique case (in_action)
                        sstq_pkg::ACT_TICK: begin
                            n_tick  = r_tick + 1'b1;
                            n_k     = '0;
                            n_pend  = 1'b0;
                            n_state = S_T_RD;
                        end
                        sstq_pkg::ACT_CREATE: begin
                            ram_we  = in_ok;
                            n_state = S_EMIT;
                            if (in_ok && r_running[in_id[IDX_W-1:0]]) begin
                                n_running[in_id[IDX_W-1:0]] = 1'b0;
                                n_state = S_FIND;
                            end
                        end
                        sstq_pkg::ACT_START: begin
                            if (!in_ok || r_running[in_id[IDX_W-1:0]]) begin
                                n_fail  = 1'b1;
                                n_state = S_EMIT;
                            end else begin
                                // expiry of the new slot is read this cycle
                                n_running[in_id[IDX_W-1:0]] = 1'b1;
                                n_state = S_ST_LD;
                            end
                        end
                        sstq_pkg::ACT_STOP: begin
                            if (!in_ok || !r_running[in_id[IDX_W-1:0]]) begin
                                n_fail  = 1'b1;
                                n_state = S_EMIT;
                            end else begin
                                n_running[in_id[IDX_W-1:0]] = 1'b0;
                                n_state = S_FIND;
                            end
                        end
                    endcase
                end
            end

            S_FIND: begin
                // search the list for the slot, then close the gap it leaves
                if (r_pos >= r_len) begin
                    n_state = S_EMIT;
                end else if (r_order[r_pos[IDX_W-1:0]] == r_id[IDX_W-1:0]) begin
                    for (int i = 0; i < N - 1; i++) begin
                        if (i >= 32'(r_pos)) begin
                            n_order[i] = r_order[i+1];
                        end
                    end
                    n_len   = r_len - 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end

            S_ST_LD: begin
                n_new_exp = ram_rdata;
                n_state   = S_W_RD;
            end

            S_W_RD: begin
                ram_raddr = r_order[r_pos[IDX_W-1:0]];
                if (r_pos >= r_len) begin
                    n_state = S_INSERT;
                end else begin
                    n_state = S_W_CMP;
                end
            end

            S_W_CMP: begin
                if (ram_rdata < r_new_exp) begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_W_RD;
                end else begin
                    n_state = S_INSERT;
                end
            end

            S_INSERT: begin
                for (int i = 1; i < N; i++) begin
                    if (i > 32'(r_pos)) begin
                        n_order[i] = r_order[i-1];
                    end
                end
                n_order[r_pos[IDX_W-1:0]] = r_id[IDX_W-1:0];
                n_len   = r_len + 1'b1;
                n_state = S_EMIT;
            end

            S_T_RD: begin
                ram_raddr = r_order[0];
                if (r_len == '0 || r_k == MAX_K) begin
                    n_state = S_T_LAST;
                end else begin
                    n_state = S_T_CMP;
                end
            end

            S_T_CMP: begin
                // hold the head address so the read data stays put while stalled
                ram_raddr = r_order[0];
                if (ram_rdata <= r_tick) begin
                    if (!r_pend || out_free) begin
                        if (r_pend) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = sstq_pkg::KIND_EXPIRED;
                            n_out_id    = sstq_pkg::ID_W'(r_pend_id);
                            n_out_fail  = 1'b0;
                            n_out_last  = 1'b0;
                        end
                        n_pend    = 1'b1;
                        n_pend_id = r_order[0];
                        n_running[r_order[0]] = 1'b0;
                        for (int i = 0; i < N - 1; i++) begin
                            n_order[i] = r_order[i+1];
                        end
                        n_len   = r_len - 1'b1;
                        n_k     = r_k + 1'b1;
                        n_state = S_T_RD;
                    end
                end else begin
                    n_state = S_T_LAST;
                end
            end

            S_T_LAST: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_fail  = 1'b0;
                    n_out_last  = 1'b1;
                    if (r_pend) begin
                        n_out_kind = sstq_pkg::KIND_EXPIRED;
                        n_out_id   = sstq_pkg::ID_W'(r_pend_id);
                    end else begin
                        n_out_kind = sstq_pkg::KIND_IDLE_TICK;
                        n_out_id   = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = sstq_pkg::KIND_REPLY;
                    n_out_id    = r_id;
                    n_out_fail  = r_fail;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_running   <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_running   <= n_running;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
        r_order    <= n_order;
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_id       <= n_id;
        r_fail     <= n_fail;
        r_new_exp  <= n_new_exp;
        r_pend_id  <= n_pend_id;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_fail <= n_out_fail;
        r_out_last <= n_out_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_fail, r_out_id};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/sstq_checker.sv]
// Port-level checker for the sorted soft timer queue, bound to the core.
// Depends on sstq_pkg and sorted_soft_timer_queue_core_defines.svh.
`include "sorted_soft_timer_queue_core_defines.svh"

module sstq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [sstq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic [1:0]                        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sstq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [1:0]                        m_axis_tuser,
    input logic                              m_axis_tlast
);

    logic [sstq_pkg::IN_TDATA_W-1:0] unused_in;
    assign unused_in = s_axis_tdata;

    // a stalled result holds
    `SSTQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // ready drops after each transfer while the command is in progress
    `SSTQ_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a tick with nothing expired is a lone, clean result
    `SSTQ_ASSERT_SAME(a_idle_tick, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == sstq_pkg::KIND_IDLE_TICK, m_axis_tlast && m_axis_tdata == '0)

    // expiry results never carry a refusal, and kind stays in range
    `SSTQ_ASSERT_SAME(a_expiry_ok, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser != 2'd3 && !(m_axis_tuser == sstq_pkg::KIND_EXPIRED && m_axis_tdata[4]))

endmodule

bind sorted_soft_timer_queue_core sstq_checker u_sstq_checker (.*);
